[hw/rtl/pwi_pkg.sv]
// shared types, constants and control word layout for the windowed-integral pid block
`default_nettype none

package pwi_pkg;

  localparam int unsigned WINDOW_DEF = 10;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned WS_W       = 20;
  localparam int unsigned DER_W      = 17;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned INIT_W     = 16;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PC_W       = 4;

  localparam int unsigned MA_W       = 34;
  localparam int unsigned MB_W       = 21;
  localparam int unsigned PROD_W     = MA_W + MB_W;
  localparam int unsigned AE_W       = 33;
  localparam int unsigned ACC_W      = 56;
  localparam int unsigned DRV_SHIFT  = 24;
  localparam int unsigned TUNE_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP    = 3'd0,
    CFG_KI    = 3'd1,
    CFG_KD    = 3'd2,
    CFG_PREV  = 3'd3,
    CFG_WSUM  = 3'd4,
    CFG_DERIV = 3'd5,
    CFG_STEP  = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    A_GAIN_P = 3'd0,
    A_GAIN_I = 3'd1,
    A_GAIN_D = 3'd2,
    A_ALPHA  = 3'd3,
    A_AE     = 3'd4
  } a_sel_e;

  typedef enum logic [1:0] {
    B_LAST  = 2'd0,
    B_SUM   = 2'd1,
    B_DERIV = 2'd2,
    B_VALUE = 2'd3
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    GW_NONE = 2'd0,
    GW_P    = 2'd1,
    GW_I    = 2'd2,
    GW_D    = 2'd3
  } gain_wr_e;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_MODE   = 2'd1,
    JMP_ALWAYS = 2'd2
  } jmp_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            mul_en;
    logic            ae_ld;
    acc_op_e         acc_op;
    gain_wr_e        gain_wr;
    logic            win_rd;
    logic            win_upd;
    logic            out_ld;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            fin;
  } ctrl_t;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] drive;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

`default_nettype wire

[hw/rtl/pwi_chan_if.sv]
// valid/ready channel interface carrying one payload per transaction
`default_nettype none

interface pwi_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pid_windowed_integral_sgd.sv]
// pid controller with sliding-window integral and gradient-descent gain tuning
//
// channels: in_i takes one item per transaction (mode, value); out_o returns
// exactly one result (drive, saturated) for each item; cfg_i writes the
// initial-value and step-size registers by index, always ready, and is to be
// used only while the block is idle, which the block itself does not enforce.
// an index past the last register is ignored. a microcoded sequencer steps
// a single shared multiplier and accumulator. an error sample (mode 0) runs
// seven microcode steps: read, window update, the three gain products, sum
// and drive; a tuning step (mode 1) runs eleven: read, alpha, three tuning
// products, the last gain write, then the three gain products, sum and drive.
// one item is worked at a time: the next is taken once the result is registered.
// the result register holds a result while the receiver stalls; the next item
// runs up to its final step and waits there until that result is taken.
// reset: gains, step size and all terms go to zero, the window reads as
// empty and its sum as zero; no clearing pass is needed.
`default_nettype none

module pid_windowed_integral_sgd import pwi_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pwi_chan_if.sink   in_i,
  pwi_chan_if.source out_o,
  pwi_chan_if.sink   cfg_i
);

  ctrl_t                   ctrl;
  cfg_wr_t                 cfg_wr;
  logic                    busy;
  logic                    in_acc;
  logic                    mode_q;
  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] last_error;
  logic signed [WS_W-1:0]  window_sum;
  logic signed [DER_W-1:0] derivative;
  logic signed [VAL_W-1:0] drive;
  logic                    saturated;
  logic                    out_valid_q;
  out_item_t               out_q;

  assign in_i.ready  = !busy;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cfg_wr.en    = cfg_i.valid && cfg_i.ready;
  assign cfg_wr.index = cfg_i.data.index;
  assign cfg_wr.wdata = cfg_i.data.wdata;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= in_i.data.mode;
      value_q <= in_i.data.value;
    end
    if (ctrl.out_ld) begin
      out_q.drive     <= drive;
      out_q.saturated <= saturated;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  pwi_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .mode_i     (mode_q),
    .out_busy_i (out_valid_q && !out_o.ready),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  pwi_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_wr),
    .value_i      (value_q),
    .last_error_o (last_error),
    .window_sum_o (window_sum),
    .derivative_o (derivative)
  );

  pwi_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_wr),
    .value_i      (value_q),
    .last_error_i (last_error),
    .window_sum_i (window_sum),
    .derivative_i (derivative),
    .drive_o      (drive),
    .saturated_o  (saturated)
  );

`ifndef SYNTHESIS
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_ld |-> !(out_valid_q && !out_o.ready))
    else $error("result register overwritten while stalled");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy)
    else $error("accepted transaction did not start the sequencer");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.out_ld))
    else $error("result valid without a load step");
`endif

endmodule

`default_nettype wire

[hw/rtl/pwi_sequencer.sv]
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module pwi_sequencer import pwi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  mode_i,
  input  logic  out_busy_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  localparam logic [PC_W-1:0] PC_READ    = 4'd0;
  localparam logic [PC_W-1:0] PC_UPDATE  = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_P   = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_I   = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL_D   = 4'd4;
  localparam logic [PC_W-1:0] PC_SUM     = 4'd5;
  localparam logic [PC_W-1:0] PC_DRIVE   = 4'd6;
  localparam logic [PC_W-1:0] PC_ALPHA   = 4'd7;
  localparam logic [PC_W-1:0] PC_TUNE_P  = 4'd8;
  localparam logic [PC_W-1:0] PC_TUNE_I  = 4'd9;
  localparam logic [PC_W-1:0] PC_TUNE_D  = 4'd10;
  localparam logic [PC_W-1:0] PC_TUNE_WR = 4'd11;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      PC_READ: begin
        w.win_rd = 1'b1;
        w.jmp    = JMP_MODE;
        w.target = PC_ALPHA;
      end
      PC_UPDATE: begin
        w.win_upd = 1'b1;
      end
      PC_MUL_P: begin
        w.a_sel  = A_GAIN_P;
        w.b_sel  = B_LAST;
        w.mul_en = 1'b1;
      end
      PC_MUL_I: begin
        w.a_sel  = A_GAIN_I;
        w.b_sel  = B_SUM;
        w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD;
      end
      PC_MUL_D: begin
        w.a_sel  = A_GAIN_D;
        w.b_sel  = B_DERIV;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD;
      end
      PC_SUM: begin
        w.acc_op = ACC_ADD;
      end
      PC_DRIVE: begin
        w.out_ld = 1'b1;
        w.fin    = 1'b1;
      end
      PC_ALPHA: begin
        w.a_sel = A_ALPHA;
        w.b_sel = B_VALUE;
        w.ae_ld = 1'b1;
      end
      PC_TUNE_P: begin
        w.a_sel  = A_AE;
        w.b_sel  = B_LAST;
        w.mul_en = 1'b1;
      end
      PC_TUNE_I: begin
        w.a_sel   = A_AE;
        w.b_sel   = B_SUM;
        w.mul_en  = 1'b1;
        w.gain_wr = GW_P;
      end
      PC_TUNE_D: begin
        w.a_sel   = A_AE;
        w.b_sel   = B_DERIV;
        w.mul_en  = 1'b1;
        w.gain_wr = GW_I;
      end
      PC_TUNE_WR: begin
        w.gain_wr = GW_D;
        w.jmp     = JMP_ALWAYS;
        w.target  = PC_MUL_P;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;
  ctrl_t           word;
  logic            stall;

  assign word   = ucode(pc_q);
  assign stall  = word.out_ld && out_busy_i;
  assign ctrl_o = (busy_q && !stall) ? word : ctrl_t'('0);
  assign busy_o = busy_q;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = PC_READ;
      end
    end else if (!stall) begin
      if (word.fin) begin
        busy_d = 1'b0;
        pc_d   = PC_READ;
      end else if (word.jmp == JMP_ALWAYS || (word.jmp == JMP_MODE && mode_i)) begin
        pc_d = word.target;
      end else begin
        pc_d = pc_q + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_READ;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pwi_window.sv]
// error window memory, running window sum, derivative and previous error
`default_nettype none

module pwi_window import pwi_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  cfg_wr_t                 cfg_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic signed [VAL_W-1:0] last_error_o,
  output logic signed [WS_W-1:0]  window_sum_o,
  output logic signed [DER_W-1:0] derivative_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = VAL_W + SLOT_W;
  localparam int unsigned CMP_W  = (SUM_W > WS_W) ? SUM_W : WS_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic signed [VAL_W-1:0] mem_q [WINDOW];
  logic signed [VAL_W-1:0] rd_q;
  logic [SLOT_W-1:0]       slot_q;
  logic                    full_q;
  logic signed [SUM_W-1:0] raw_q, raw_d;
  logic signed [VAL_W-1:0] last_q;
  logic signed [WS_W-1:0]  wsum_q, wsum_clip;
  logic signed [DER_W-1:0] deriv_q;
  logic signed [VAL_W-1:0] old_val;
  logic signed [CMP_W-1:0] raw_ext;
  logic                    fits;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.win_rd) begin
      rd_q <= mem_q[slot_q];
    end
    if (ctrl_i.win_upd) begin
      mem_q[slot_q] <= value_i;
    end
  end

  // slots are filled in order, so an entry is unwritten until the first wrap
  assign old_val = full_q ? rd_q : '0;
  assign raw_d   = raw_q + SUM_W'(value_i) - SUM_W'(old_val);
  assign raw_ext = CMP_W'(raw_d);
  assign fits    = (raw_ext[CMP_W-1:WS_W-1] == '0) || (raw_ext[CMP_W-1:WS_W-1] == '1);

  always_comb begin
    if (fits) begin
      wsum_clip = raw_ext[WS_W-1:0];
    end else if (raw_ext[CMP_W-1]) begin
      wsum_clip = {1'b1, {(WS_W-1){1'b0}}};
    end else begin
      wsum_clip = {1'b0, {(WS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      full_q  <= 1'b0;
      raw_q   <= '0;
      last_q  <= '0;
      wsum_q  <= '0;
      deriv_q <= '0;
    end else if (ctrl_i.win_upd) begin
      slot_q  <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
      full_q  <= full_q || (slot_q == SLOT_LAST);
      raw_q   <= raw_d;
      wsum_q  <= wsum_clip;
      deriv_q <= DER_W'(value_i) - DER_W'(last_q);
      last_q  <= value_i;
    end else if (cfg_i.en) begin
      case (cfg_i.index)
        CFG_PREV:  last_q  <= cfg_i.wdata[VAL_W-1:0];
        CFG_WSUM:  wsum_q  <= cfg_i.wdata[WS_W-1:0];
        CFG_DERIV: deriv_q <= cfg_i.wdata[DER_W-1:0];
        default: ;
      endcase
    end
  end

  assign last_error_o = last_q;
  assign window_sum_o = wsum_q;
  assign derivative_o = deriv_q;

endmodule

`default_nettype wire

[hw/rtl/pwi_datapath.sv]
// gains, shared multiplier, accumulator, gain update and drive rounding
`default_nettype none

module pwi_datapath import pwi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  cfg_wr_t                 cfg_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] last_error_i,
  input  logic signed [WS_W-1:0]  window_sum_i,
  input  logic signed [DER_W-1:0] derivative_i,
  output logic signed [VAL_W-1:0] drive_o,
  output logic                    saturated_o
);

  localparam int unsigned GS_W  = PROD_W + 1;
  localparam int unsigned RND_W = ACC_W - DRV_SHIFT;
  localparam int unsigned NEG_W = RND_W + 1;
  localparam logic signed [ACC_W-1:0]  DRV_HALF  = ACC_W'(1) << (DRV_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] TUNE_HALF = PROD_W'(1) << (TUNE_SHIFT - 1);

  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [ALPHA_W-1:0]       alpha_q;
  logic signed [AE_W-1:0]   ae_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] delta;
  logic signed [GAIN_W-1:0] gain_sel, gain_new, gain_cfg;
  logic signed [GS_W-1:0]   gain_sum;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [NEG_W-1:0]  neg_drive;
  logic                     drv_fits;

  always_comb begin
    case (ctrl_i.a_sel)
      A_GAIN_P: mul_a = MA_W'(gain_p_q);
      A_GAIN_I: mul_a = MA_W'(gain_i_q);
      A_GAIN_D: mul_a = MA_W'(gain_d_q);
      A_ALPHA:  mul_a = MA_W'($signed({1'b0, alpha_q}));
      A_AE:     mul_a = MA_W'(ae_q);
      default:  mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      B_LAST:  mul_b = MB_W'(last_error_i);
      B_SUM:   mul_b = MB_W'(window_sum_i);
      B_DERIV: mul_b = MB_W'(derivative_i);
      B_VALUE: mul_b = MB_W'(value_i);
      default: mul_b = '0;
    endcase
  end

  assign mult = mul_a * mul_b;

  // gain update: round the product to q8.24 and saturate the new gain
  assign delta = (prod_q + TUNE_HALF) >>> TUNE_SHIFT;

  always_comb begin
    case (ctrl_i.gain_wr)
      GW_P:    gain_sel = gain_p_q;
      GW_I:    gain_sel = gain_i_q;
      GW_D:    gain_sel = gain_d_q;
      default: gain_sel = '0;
    endcase
  end

  assign gain_sum = GS_W'(gain_sel) + GS_W'(delta);

  always_comb begin
    if ((gain_sum[GS_W-1:GAIN_W-1] == '0) || (gain_sum[GS_W-1:GAIN_W-1] == '1)) begin
      gain_new = gain_sum[GAIN_W-1:0];
    end else if (gain_sum[GS_W-1]) begin
      gain_new = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      gain_new = {1'b0, {(GAIN_W-1){1'b1}}};
    end
  end

  assign gain_cfg = GAIN_W'($signed({cfg_i.wdata[INIT_W-1:0], {FRAC_SHIFT{1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mult;
    end
    if (ctrl_i.ae_ld) begin
      ae_q <= mult[AE_W-1:0];
    end
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_q <= ACC_W'(prod_q);
      ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      alpha_q  <= '0;
    end else if (ctrl_i.gain_wr != GW_NONE) begin
      case (ctrl_i.gain_wr)
        GW_P:    gain_p_q <= gain_new;
        GW_I:    gain_i_q <= gain_new;
        GW_D:    gain_d_q <= gain_new;
        default: ;
      endcase
    end else if (cfg_i.en) begin
      case (cfg_i.index)
        CFG_KP:   gain_p_q <= gain_cfg;
        CFG_KI:   gain_i_q <= gain_cfg;
        CFG_KD:   gain_d_q <= gain_cfg;
        CFG_STEP: alpha_q  <= cfg_i.wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // drive = -round(acc / 2^24), clipped to 16 bits
  assign acc_rnd   = acc_q + DRV_HALF;
  assign neg_drive = -NEG_W'($signed(acc_rnd[ACC_W-1:DRV_SHIFT]));
  assign drv_fits  = (neg_drive[NEG_W-1:VAL_W-1] == '0) || (neg_drive[NEG_W-1:VAL_W-1] == '1);

  always_comb begin
    saturated_o = !drv_fits;
    if (drv_fits) begin
      drive_o = neg_drive[VAL_W-1:0];
    end else if (neg_drive[NEG_W-1]) begin
      drive_o = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      drive_o = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[tb/tb_pid_windowed_integral_sgd.sv]
// self-checking testbench for the windowed-integral pid controller with gain tuning
`timescale 1ns / 1ps

module tb_pid_windowed_integral_sgd;
  import pwi_pkg::*;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TUNE   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 65;

  logic clk_i;
  logic rst_ni;

  pwi_chan_if #(.T(in_item_t))  in_if  ();
  pwi_chan_if #(.T(out_item_t)) out_if ();
  pwi_chan_if #(.T(cfg_item_t)) cfg_if ();

  pid_windowed_integral_sgd DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // controller state as seen by the checker
  logic signed [VAL_W-1:0]  err_win [WINDOW_DEF] = '{default: '0};
  int                       win_slot   = 0;
  logic signed [WS_W-1:0]   win_sum    = '0;
  logic signed [VAL_W-1:0]  last_err   = '0;
  logic signed [DER_W-1:0]  deriv_term = '0;
  logic signed [GAIN_W-1:0] gain_p     = '0;
  logic signed [GAIN_W-1:0] gain_i     = '0;
  logic signed [GAIN_W-1:0] gain_d     = '0;
  logic [ALPHA_W-1:0]       alpha      = '0;

  in_item_t  pending_items[$];
  out_item_t drive_expected[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  logic hold_arm     = 1'b0;
  int quiet_cycles   = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint round_q(longint x, int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [GAIN_W-1:0] tuned(logic signed [GAIN_W-1:0] g,
                                                      longint ae, longint term);
    longint s;
    s = longint'(g) + round_q(ae * term, TUNE_SHIFT);
    return 32'(clip(s, -64'sd2147483648, 64'sd2147483647));
  endfunction

  task automatic pid_step(input in_item_t it);
    longint acc_sum, d, c, ae;
    int total;
    out_item_t r;
    logic signed [GAIN_W-1:0] np, ni, nd;
    if (it.mode == MODE_SAMPLE) begin
      err_win[win_slot] = it.value;
      win_slot = (win_slot + 1) % WINDOW_DEF;
      total = 0;
      for (int k = 0; k < WINDOW_DEF; k++) total += err_win[k];
      win_sum    = 20'(clip(total, -524288, 524287));
      deriv_term = 17'(int'(it.value) - int'(last_err));
      last_err   = it.value;
    end else begin
      ae = longint'(alpha) * longint'(it.value);
      np = tuned(gain_p, ae, longint'(last_err));
      ni = tuned(gain_i, ae, longint'(win_sum));
      nd = tuned(gain_d, ae, longint'(deriv_term));
      gain_p = np;
      gain_i = ni;
      gain_d = nd;
    end
    acc_sum = longint'(gain_p) * longint'(last_err)
            + longint'(gain_i) * longint'(win_sum)
            + longint'(gain_d) * longint'(deriv_term);
    d = -round_q(acc_sum, DRV_SHIFT);
    c = clip(d, -32768, 32767);
    r.drive     = 16'(c);
    r.saturated = (c != d);
    drive_expected = {drive_expected, r};
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wd);
    case (idx)
      CFG_KP:    gain_p = {{4{wd[15]}}, wd[15:0], 12'd0};
      CFG_KI:    gain_i = {{4{wd[15]}}, wd[15:0], 12'd0};
      CFG_KD:    gain_d = {{4{wd[15]}}, wd[15:0], 12'd0};
      CFG_PREV:  last_err = wd[15:0];
      CFG_WSUM:  win_sum = wd[19:0];
      CFG_DERIV: deriv_term = wd[16:0];
      CFG_STEP:  alpha = wd[15:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wd);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.wdata <= wd;
    do @(posedge clk_i); while (!cfg_if.ready);
    load_reg(idx, wd);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_item(input logic mode, input logic [VAL_W-1:0] value);
    in_item_t it;
    it.mode  = mode;
    it.value = value;
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || drive_expected.size() != 0);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    if ($urandom_range(1) == 0) return 16'($urandom);
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  task automatic set_idling(input int sel);
    case (sel)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) pid_step(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_items.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (drive_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: drive %0d saturated %0b",
                     out_if.data.drive, out_if.data.saturated);
        end else begin
          want = drive_expected.pop_front();
          if (want.drive !== out_if.data.drive || want.saturated !== out_if.data.saturated) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: drive exp %0d got %0d, saturated exp %0b got %0b",
                       want.drive, out_if.data.drive, want.saturated,
                       out_if.data.saturated);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.data        = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains give zero drive
    push_item(MODE_SAMPLE, 16'h1234);
    push_item(MODE_TUNE, 16'h7fff);
    wait_idle();

    write_reg(CFG_KP, 20'h01000);
    write_reg(CFG_KI, 20'h00100);
    write_reg(CFG_KD, 20'h00800);
    write_reg(CFG_PREV, 20'h00100);
    write_reg(CFG_WSUM, 20'h00400);
    write_reg(CFG_DERIV, 20'h00200);
    write_reg(CFG_STEP, 20'h00100);
    write_reg(CFG_UNUSED, 20'hfffff);

    // tune on loaded terms, field extremes, window wrap, saturation
    push_item(MODE_TUNE, 16'h0000);
    push_item(MODE_SAMPLE, 16'h7fff);
    push_item(MODE_SAMPLE, 16'h8000);
    push_item(MODE_SAMPLE, 16'h0000);
    push_item(MODE_SAMPLE, 16'h0001);
    push_item(MODE_SAMPLE, 16'hffff);
    for (int k = 1; k <= 7; k++) push_item(MODE_SAMPLE, 16'(k * 300 - 1000));
    push_item(MODE_TUNE, 16'h7fff);
    push_item(MODE_TUNE, 16'h8000);
    push_item(MODE_SAMPLE, 16'h7fff);
    push_item(MODE_SAMPLE, 16'h7fff);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_KP, 20'h08000);
        write_reg(CFG_KI, 20'hf8000);
        write_reg(CFG_KD, 20'h08000);
        write_reg(CFG_PREV, 20'h08000);
        write_reg(CFG_WSUM, 20'h80000);
        write_reg(CFG_DERIV, 20'h10000);
        write_reg(CFG_STEP, 20'h0ffff);
      end else if (ph == 1) begin
        write_reg(CFG_KP, 20'h07fff);
        write_reg(CFG_KI, 20'h07fff);
        write_reg(CFG_KD, 20'hf7fff);
        write_reg(CFG_PREV, 20'h07fff);
        write_reg(CFG_WSUM, 20'h7ffff);
        write_reg(CFG_DERIV, 20'h0ffff);
        write_reg(CFG_STEP, 20'h00000);
      end else begin
        write_reg(CFG_KP, {4'($urandom), rand_gain()});
        write_reg(CFG_KI, {4'($urandom), rand_gain()});
        write_reg(CFG_KD, {4'($urandom), rand_gain()});
        write_reg(CFG_PREV, {4'($urandom), rand_value()});
        write_reg(CFG_WSUM, 20'($urandom));
        write_reg(CFG_DERIV, 20'($urandom));
        if ($urandom_range(3) == 0) write_reg(CFG_STEP, 20'($urandom));
        else write_reg(CFG_STEP, {4'($urandom), 16'($urandom_range(511))});
      end
      if (ph == 4) begin
        // receiver held off while the sender keeps offering
        set_idling(0);
        for (int k = 0; k < 40; k++)
          push_item($urandom_range(3) == 0 ? MODE_TUNE : MODE_SAMPLE, rand_value());
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end else begin
        set_idling(ph % 4);
        for (int k = 0; k < PHASE_ITEMS; k++)
          push_item($urandom_range(3) == 0 ? MODE_TUNE : MODE_SAMPLE, rand_value());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    mismatch_count += drive_expected.size();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pwi_pkg.sv
hw/rtl/pwi_chan_if.sv
hw/rtl/pwi_sequencer.sv
hw/rtl/pwi_window.sv
hw/rtl/pwi_datapath.sv
hw/rtl/pid_windowed_integral_sgd.sv
tb/tb_pid_windowed_integral_sgd.sv
